@@ design/trapezoidal_joint_profile_assert.svh @@
// Assertion macros for the trapezoidal joint profile block.
// Included by the RTL files that carry concurrent assertions.
`ifndef TRAPEZOIDAL_JOINT_PROFILE_ASSERT_SVH
`define TRAPEZOIDAL_JOINT_PROFILE_ASSERT_SVH
`ifndef SYNTHESIS
`define TJP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TJP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TJP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define TJP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/tjp_pkg.sv @@
// Shared types and constants of the trapezoidal joint profile block.
// Used by tjp_iter_unit and trapezoidal_joint_profile; depends on nothing.
`default_nettype none

package tjp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LD_CHECK,
        ST_LD_MVV,
        ST_LD_MDA,
        ST_LD_CMP,
        ST_LD_DIV1,
        ST_LD_SQRT,
        ST_LD_DIV2,
        ST_LD_STORE,
        ST_SM_CEND,
        ST_SM_CLASS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_SM_POS
    } state_t;

    typedef enum logic {
        IU_DIV,
        IU_SQRT
    } iu_mode_t;

    typedef struct packed {
        logic     go;
        iu_mode_t mode;
    } iu_ctrl_t;

    typedef enum logic [1:0] {
        MSTEP_AT,
        MSTEP_AT2,
        MSTEP_VT
    } mstep_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECT   = 2'd1;
    localparam logic [1:0] STATUS_UNLOADED = 2'd2;

    localparam logic [1:0] SEG_ACCEL  = 2'd0;
    localparam logic [1:0] SEG_CRUISE = 2'd1;
    localparam logic [1:0] SEG_DECEL  = 2'd2;
    localparam logic [1:0] SEG_DONE   = 2'd3;

    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    // Products are clamped at 2^48 before use.
    localparam logic [63:0] MQ_CAP = 64'h0001_0000_0000_0000;

endpackage

`default_nettype wire

@@ design/trapezoidal_joint_profile.sv @@
// Top level of the trapezoidal joint profile generator: sequencer, shared
// 32x32 multiplier, per-joint profile store and result registers.
// Depends on tjp_pkg, tjp_iter_unit and trapezoidal_joint_profile_assert.svh.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ------------------------------------------------
//   request   start / busy       op, joint, time_req, start_pos, end_pos,
//                                max_velocity, max_acceleration
//   result    done (1 cycle)     status, position, velocity, acceleration, segment
//
// A request is taken when start is high and busy is low; busy stays high until
// the result is registered, and done then pulses for exactly one cycle.
// A sample for a finished segment skips the multiplier; any other sample runs
// two or three 48x32 products as two passes each on the shared multiplier.
// A load runs a division and then a square root for a triangular profile, or
// two divisions for a trapezoidal one, on the one-bit-a-cycle divider and square
// root; a rejected load stops at the check. Reset clears the sequencer and every
// joint's loaded flag. The receiver cannot stall, so results are never held back.
`default_nettype none

`include "trapezoidal_joint_profile_assert.svh"

module trapezoidal_joint_profile #(
    parameter int NUM_JOINTS = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic               joint,
    input  logic [31:0]        time_req,
    input  logic signed [31:0] start_pos,
    input  logic signed [31:0] end_pos,
    input  logic [30:0]        max_velocity,
    input  logic [30:0]        max_acceleration,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] position,
    output logic signed [31:0] velocity,
    output logic signed [31:0] acceleration,
    output logic [1:0]         segment
);

    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // Saturate a wide signed position to 32 bits.
    function automatic logic [31:0] sat_s32(input logic signed [51:0] v);
        logic [31:0] r;
        if (v > 52'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -52'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Sequencer state.
    tjp_pkg::state_t state_reg;
    tjp_pkg::state_t state_next;
    logic            done_reg;
    logic [NUM_JOINTS-1:0] loaded_reg;

    // Captured request.
    logic               op_reg;
    logic               joint_reg;
    logic [31:0]        t_reg;
    logic signed [31:0] qs_in_reg;
    logic signed [31:0] qe_in_reg;
    logic [30:0]        v_in_reg;
    logic [30:0]        a_in_reg;

    // Per-joint stored profile.
    logic signed [31:0] prof_qs [NUM_JOINTS];
    logic signed [31:0] prof_qe [NUM_JOINTS];
    logic [30:0]        prof_v  [NUM_JOINTS];
    logic [30:0]        prof_a  [NUM_JOINTS];
    logic [31:0]        prof_tc [NUM_JOINTS];
    logic [31:0]        prof_tf [NUM_JOINTS];
    logic               prof_tri[NUM_JOINTS];

    // Working registers.
    logic [31:0]     d_reg;
    logic            tri_reg;
    logic [31:0]     tc_reg;
    logic [31:0]     tf_reg;
    logic [31:0]     cend_reg;
    logic [1:0]      seg_reg;
    logic [31:0]     tt_reg;
    logic [31:0]     dt_reg;
    tjp_pkg::mstep_t mstep_reg;
    logic [63:0]     prod_reg;
    logic [79:0]     acc_reg;
    logic [48:0]     m1_reg;
    logic [48:0]     m2_reg;
    logic [48:0]     m3_reg;

    // Result registers.
    logic [1:0]  status_reg;
    logic [31:0] pos_reg;
    logic [31:0] vel_reg;
    logic [31:0] accl_reg;
    logic [1:0]  seg_out_reg;

    // Control from the output decoder.
    logic              finish;
    logic [1:0]        fin_status;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    tjp_pkg::iu_ctrl_t iu_ctrl;
    logic [63:0]       iu_operand;
    logic [31:0]       iu_divisor;
    logic              iu_done;
    logic [63:0]       iu_result;

    // Datapath helpers.
    logic [JW-1:0]      idx;
    logic               jvalid;
    logic signed [32:0] ld_diff;
    logic               reject;
    logic               tri_now;
    logic [47:0]        mx;
    logic [31:0]        my;
    logic [79:0]        sum80;
    logic [63:0]        mshift;
    logic [48:0]        mres;
    logic [1:0]         seg_now;
    logic [31:0]        tt_now;
    logic [32:0]        tf_dbl;
    logic [49:0]        tf_sum;
    logic signed [51:0] pos_base;
    logic signed [51:0] pos_half;
    logic signed [51:0] pos_lin;
    logic signed [51:0] pos_w;
    logic [31:0]        vel_now;
    logic [31:0]        accl_now;

    assign idx    = JW'(joint_reg);
    assign jvalid = (int'(joint_reg) < NUM_JOINTS);

    assign ld_diff = {qe_in_reg[31], qe_in_reg} - {qs_in_reg[31], qs_in_reg};
    assign reject  = ld_diff[32];
    assign tri_now = (acc_reg[63:0] >= prod_reg);

    // Operands of the current 48x32 product.
    always_comb
    begin
        unique case (mstep_reg)
            tjp_pkg::MSTEP_AT:
            begin
                mx = {17'b0, prof_a[idx]};
                my = tt_reg;
            end
            tjp_pkg::MSTEP_AT2:
            begin
                mx = m1_reg[47:0];
                my = tt_reg;
            end
            tjp_pkg::MSTEP_VT:
            begin
                mx = {17'b0, prof_v[idx]};
                my = dt_reg;
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    // Second pass: add the high partial product, drop 16 fraction bits, clamp.
    assign sum80  = acc_reg + {prod_reg[47:0], 32'b0};
    assign mshift = sum80[79:16];
    assign mres   = (mshift > tjp_pkg::MQ_CAP) ? tjp_pkg::MQ_CAP[48:0] : mshift[48:0];

    // Segment of the sample time and the time argument of the quadratic term.
    always_comb
    begin
        if (t_reg <= prof_tc[idx])
        begin
            seg_now = tjp_pkg::SEG_ACCEL;
            tt_now  = t_reg;
        end
        else if (t_reg <= cend_reg)
        begin
            seg_now = tjp_pkg::SEG_CRUISE;
            tt_now  = prof_tc[idx];
        end
        else if (t_reg <= prof_tf[idx])
        begin
            seg_now = tjp_pkg::SEG_DECEL;
            tt_now  = prof_tf[idx] - t_reg;
        end
        else
        begin
            seg_now = tjp_pkg::SEG_DONE;
            tt_now  = '0;
        end
    end

    assign tf_dbl = {iu_result[31:0], 1'b0};
    assign tf_sum = {1'b0, iu_result[48:0]} + {18'b0, tc_reg};

    // Final position, velocity and acceleration of a sample.
    always_comb
    begin
        pos_half = 52'(signed'({4'b0, m2_reg[48:1]}));
        pos_lin  = '0;
        vel_now  = '0;
        accl_now = '0;
        if (seg_reg == tjp_pkg::SEG_DECEL || seg_reg == tjp_pkg::SEG_DONE)
            pos_base = 52'(prof_qe[idx]);
        else
            pos_base = 52'(prof_qs[idx]);
        unique case (seg_reg)
            tjp_pkg::SEG_ACCEL:
            begin
                vel_now  = (|m1_reg[48:31]) ? 32'h7FFF_FFFF : {1'b0, m1_reg[30:0]};
                accl_now = {1'b0, prof_a[idx]};
            end
            tjp_pkg::SEG_CRUISE:
            begin
                pos_lin = 52'(signed'({3'b0, m3_reg}));
                vel_now = {1'b0, prof_v[idx]};
            end
            tjp_pkg::SEG_DECEL:
            begin
                pos_half = -pos_half;
                vel_now  = (|m1_reg[48:31]) ? 32'h7FFF_FFFF : {1'b0, m1_reg[30:0]};
                accl_now = 32'd0 - {1'b0, prof_a[idx]};
            end
            default:
            begin
                pos_half = '0;
            end
        endcase
        pos_w = pos_base + pos_half + pos_lin;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tjp_pkg::ST_IDLE:
                if (start)
                    state_next = tjp_pkg::ST_DISPATCH;
            tjp_pkg::ST_DISPATCH:
            begin
                if (!jvalid)
                    state_next = tjp_pkg::ST_IDLE;
                else if (!op_reg)
                    state_next = tjp_pkg::ST_LD_CHECK;
                else if (!loaded_reg[idx])
                    state_next = tjp_pkg::ST_IDLE;
                else
                    state_next = tjp_pkg::ST_SM_CEND;
            end
            tjp_pkg::ST_LD_CHECK:
                state_next = reject ? tjp_pkg::ST_IDLE : tjp_pkg::ST_LD_MVV;
            tjp_pkg::ST_LD_MVV:
                state_next = tjp_pkg::ST_LD_MDA;
            tjp_pkg::ST_LD_MDA:
                state_next = tjp_pkg::ST_LD_CMP;
            tjp_pkg::ST_LD_CMP:
                state_next = tjp_pkg::ST_LD_DIV1;
            tjp_pkg::ST_LD_DIV1:
                if (iu_done)
                    state_next = tri_reg ? tjp_pkg::ST_LD_SQRT : tjp_pkg::ST_LD_DIV2;
            tjp_pkg::ST_LD_SQRT,
            tjp_pkg::ST_LD_DIV2:
                if (iu_done)
                    state_next = tjp_pkg::ST_LD_STORE;
            tjp_pkg::ST_LD_STORE:
                state_next = tjp_pkg::ST_IDLE;
            tjp_pkg::ST_SM_CEND:
                state_next = tjp_pkg::ST_SM_CLASS;
            tjp_pkg::ST_SM_CLASS:
                state_next = (seg_now == tjp_pkg::SEG_DONE) ? tjp_pkg::ST_SM_POS
                                                            : tjp_pkg::ST_MUL_LO;
            tjp_pkg::ST_MUL_LO:
                state_next = tjp_pkg::ST_MUL_HI;
            tjp_pkg::ST_MUL_HI:
                state_next = tjp_pkg::ST_MUL_ACC;
            tjp_pkg::ST_MUL_ACC:
            begin
                if (mstep_reg == tjp_pkg::MSTEP_AT)
                    state_next = tjp_pkg::ST_MUL_LO;
                else if (mstep_reg == tjp_pkg::MSTEP_AT2 && seg_reg == tjp_pkg::SEG_CRUISE)
                    state_next = tjp_pkg::ST_MUL_LO;
                else
                    state_next = tjp_pkg::ST_SM_POS;
            end
            tjp_pkg::ST_SM_POS:
                state_next = tjp_pkg::ST_IDLE;
            default:
                state_next = tjp_pkg::ST_IDLE;
        endcase
    end

    // Output decoder: multiplier operands, iterative unit requests, completion.
    always_comb
    begin
        finish       = 1'b0;
        fin_status   = tjp_pkg::STATUS_OK;
        mul_a        = '0;
        mul_b        = '0;
        iu_ctrl.go   = 1'b0;
        iu_ctrl.mode = tjp_pkg::IU_DIV;
        iu_operand   = '0;
        iu_divisor   = '0;
        unique case (state_reg)
            tjp_pkg::ST_DISPATCH:
            begin
                if (!jvalid || (op_reg && !loaded_reg[idx]))
                begin
                    finish     = 1'b1;
                    fin_status = tjp_pkg::STATUS_UNLOADED;
                end
            end
            tjp_pkg::ST_LD_CHECK:
            begin
                if (reject)
                begin
                    finish     = 1'b1;
                    fin_status = tjp_pkg::STATUS_REJECT;
                end
            end
            tjp_pkg::ST_LD_MVV:
            begin
                mul_a = {1'b0, v_in_reg};
                mul_b = {1'b0, v_in_reg};
            end
            tjp_pkg::ST_LD_MDA:
            begin
                mul_a = d_reg;
                mul_b = {1'b0, a_in_reg};
            end
            tjp_pkg::ST_LD_CMP:
            begin
                // Triangular: D*2^32/A, then its root. Otherwise V*2^16/A.
                iu_ctrl.go = 1'b1;
                iu_operand = tri_now ? {d_reg, 32'b0} : {17'b0, v_in_reg, 16'b0};
                iu_divisor = {1'b0, a_in_reg};
            end
            tjp_pkg::ST_LD_DIV1:
            begin
                if (iu_done)
                begin
                    iu_ctrl.go = 1'b1;
                    if (tri_reg)
                    begin
                        iu_ctrl.mode = tjp_pkg::IU_SQRT;
                        iu_operand   = iu_result;
                    end
                    else
                    begin
                        iu_operand = {16'b0, d_reg, 16'b0};
                        iu_divisor = {1'b0, v_in_reg};
                    end
                end
            end
            tjp_pkg::ST_LD_STORE,
            tjp_pkg::ST_SM_POS:
                finish = 1'b1;
            tjp_pkg::ST_MUL_LO:
            begin
                mul_a = mx[31:0];
                mul_b = my;
            end
            tjp_pkg::ST_MUL_HI:
            begin
                mul_a = {16'b0, mx[47:32]};
                mul_b = my;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    tjp_iter_unit u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (iu_ctrl),
        .operand (iu_operand),
        .divisor (iu_divisor),
        .done    (iu_done),
        .result  (iu_result)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tjp_pkg::ST_IDLE;
            done_reg   <= 1'b0;
            loaded_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (state_reg == tjp_pkg::ST_LD_STORE)
                loaded_reg[idx] <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            tjp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_reg    <= op;
                    joint_reg <= joint;
                    t_reg     <= time_req;
                    qs_in_reg <= start_pos;
                    qe_in_reg <= end_pos;
                    // A zero limit is taken as one LSB.
                    v_in_reg  <= (max_velocity == '0) ? 31'd1 : max_velocity;
                    a_in_reg  <= (max_acceleration == '0) ? 31'd1 : max_acceleration;
                end
            end
            tjp_pkg::ST_LD_CHECK:
                d_reg <= ld_diff[31:0];
            tjp_pkg::ST_LD_MDA:
                acc_reg <= {16'b0, prod_reg};
            tjp_pkg::ST_LD_CMP:
                tri_reg <= tri_now;
            tjp_pkg::ST_LD_DIV1:
            begin
                if (iu_done && !tri_reg)
                    tc_reg <= (|iu_result[63:32]) ? 32'hFFFF_FFFF : iu_result[31:0];
            end
            tjp_pkg::ST_LD_SQRT:
            begin
                if (iu_done)
                begin
                    tc_reg <= iu_result[31:0];
                    tf_reg <= tf_dbl[32] ? 32'hFFFF_FFFF : tf_dbl[31:0];
                end
            end
            tjp_pkg::ST_LD_DIV2:
            begin
                if (iu_done)
                    tf_reg <= (|tf_sum[49:32]) ? 32'hFFFF_FFFF : tf_sum[31:0];
            end
            tjp_pkg::ST_LD_STORE:
            begin
                prof_qs[idx]  <= qs_in_reg;
                prof_qe[idx]  <= qe_in_reg;
                prof_v[idx]   <= v_in_reg;
                prof_a[idx]   <= a_in_reg;
                prof_tc[idx]  <= tc_reg;
                prof_tf[idx]  <= tf_reg;
                prof_tri[idx] <= tri_reg;
            end
            tjp_pkg::ST_SM_CEND:
                cend_reg <= prof_tri[idx] ? prof_tc[idx] : prof_tf[idx] - prof_tc[idx];
            tjp_pkg::ST_SM_CLASS:
            begin
                seg_reg   <= seg_now;
                tt_reg    <= tt_now;
                dt_reg    <= t_reg - prof_tc[idx];
                mstep_reg <= tjp_pkg::MSTEP_AT;
            end
            tjp_pkg::ST_MUL_HI:
                acc_reg <= {16'b0, prod_reg};
            tjp_pkg::ST_MUL_ACC:
            begin
                unique case (mstep_reg)
                    tjp_pkg::MSTEP_AT:
                    begin
                        m1_reg    <= mres;
                        mstep_reg <= tjp_pkg::MSTEP_AT2;
                    end
                    tjp_pkg::MSTEP_AT2:
                    begin
                        m2_reg    <= mres;
                        mstep_reg <= tjp_pkg::MSTEP_VT;
                    end
                    default:
                        m3_reg <= mres;
                endcase
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            status_reg <= fin_status;
            if (state_reg == tjp_pkg::ST_SM_POS)
            begin
                pos_reg     <= sat_s32(pos_w);
                vel_reg     <= vel_now;
                accl_reg    <= accl_now;
                seg_out_reg <= seg_reg;
            end
            else
            begin
                pos_reg     <= '0;
                vel_reg     <= '0;
                accl_reg    <= '0;
                seg_out_reg <= tjp_pkg::SEG_ACCEL;
            end
        end
    end

    assign busy         = (state_reg != tjp_pkg::ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign position     = pos_reg;
    assign velocity     = vel_reg;
    assign acceleration = accl_reg;
    assign segment      = seg_out_reg;

    `TJP_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, start && !busy, state_reg == tjp_pkg::ST_DISPATCH, "accepted request did not reach dispatch")
    `TJP_ASSERT_IMPLY(a_done_idle, clk, rst_n, done_reg, state_reg == tjp_pkg::ST_IDLE, "result strobe while sequencer busy")
    `TJP_ASSERT_IMPLY(a_iu_wait, clk, rst_n, iu_done, state_reg == tjp_pkg::ST_LD_DIV1 || state_reg == tjp_pkg::ST_LD_SQRT || state_reg == tjp_pkg::ST_LD_DIV2, "iterative unit finished outside a wait state")
    `TJP_ASSERT_IMPLY(a_finished_rest, clk, rst_n, done_reg && status_reg == tjp_pkg::STATUS_OK && seg_out_reg == tjp_pkg::SEG_DONE, vel_reg == '0 && accl_reg == '0, "finished segment reports motion")

endmodule

`default_nettype wire

@@ design/tjp_iter_unit.sv @@
// Iterative divider (64 by 32 bits, one quotient bit a cycle) and square
// root (64 bits, one root bit a cycle) sharing one subtract-compare path.
// Depends on tjp_pkg.
`default_nettype none

module tjp_iter_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  tjp_pkg::iu_ctrl_t ctrl,
    input  logic [63:0]       operand,
    input  logic [31:0]       divisor,
    output logic              done,
    output logic [63:0]       result
);

    logic              busy_reg;
    logic              done_reg;
    tjp_pkg::iu_mode_t mode_reg;
    logic [6:0]        cnt_reg;
    logic [63:0]       x_reg;
    logic [31:0]       div_reg;
    logic [34:0]       rem_reg;
    logic [63:0]       q_reg;

    logic [34:0] shifted;
    logic [34:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb
    begin
        if (mode_reg == tjp_pkg::IU_DIV)
        begin
            shifted = {rem_reg[33:0], x_reg[63]};
            trial   = {3'b000, div_reg};
        end
        else
        begin
            shifted = {rem_reg[32:0], x_reg[63:62]};
            trial   = {q_reg[32:0], 2'b01};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[35];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= tjp_pkg::IU_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.go)
            begin
                busy_reg <= 1'b1;
                mode_reg <= ctrl.mode;
                cnt_reg  <= (ctrl.mode == tjp_pkg::IU_DIV) ? tjp_pkg::DIV_STEPS
                                                           : tjp_pkg::SQRT_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            x_reg   <= operand;
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= (mode_reg == tjp_pkg::IU_DIV) ? {x_reg[62:0], 1'b0}
                                                     : {x_reg[61:0], 2'b00};
            rem_reg <= ge ? diff[34:0] : shifted;
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the trapezoidal joint profile generator.
// Depends on tjp_pkg and trapezoidal_joint_profile; drives loads and samples and checks results.
`timescale 1ns / 1ps

module testbench;

    localparam int NJ = 2;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        op;
        logic        joint;
        logic [31:0] t;
        logic [31:0] qs;
        logic [31:0] qe;
        logic [30:0] v;
        logic [30:0] a;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [1:0]  seg;
    } motion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic op = 1'b0;
    logic joint = 1'b0;
    logic [31:0] time_req = '0;
    logic signed [31:0] start_pos = '0;
    logic signed [31:0] end_pos = '0;
    logic [30:0] max_velocity = 31'd1;
    logic [30:0] max_acceleration = 31'd1;
    logic done;
    logic [1:0] status;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic [1:0] segment;

    trapezoidal_joint_profile #(.NUM_JOINTS(NJ)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .joint(joint), .time_req(time_req), .start_pos(start_pos),
        .end_pos(end_pos), .max_velocity(max_velocity),
        .max_acceleration(max_acceleration), .done(done), .status(status),
        .position(position), .velocity(velocity),
        .acceleration(acceleration), .segment(segment)
    );

    always #5 clk = ~clk;

    // Per-joint copy of the profile store that the predictor keeps.
    logic signed [63:0] prof_qs [NJ];
    logic signed [63:0] prof_qe [NJ];
    logic [31:0] prof_v [NJ];
    logic [31:0] prof_a [NJ];
    logic [31:0] prof_tc [NJ];
    logic [31:0] prof_tf [NJ];
    logic prof_tri [NJ];
    logic prof_loaded [NJ];

    request_t pending_requests[$];
    motion_t expected_motion[$];

    int idle_pct = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int loads_sent = 0;
    int samples_sent = 0;
    int stall_cycles = 0;
    logic timed_out = 1'b0;

    // floor(x*y/2^16), clamped at 2^48 as the block does.
    function automatic logic [63:0] mul_q16(logic [63:0] x, logic [63:0] y);
        logic [127:0] p;
        logic [127:0] r;
        begin
            p = x * y;
            if (p[127:64] != 0) return tjp_pkg::MQ_CAP;
            r = p >> 16;
            return (r > tjp_pkg::MQ_CAP) ? tjp_pkg::MQ_CAP : r[63:0];
        end
    endfunction

    function automatic logic [63:0] half_accel_dist(logic [63:0] a, logic [63:0] t);
        begin
            return mul_q16(mul_q16(a, t), t) >> 1;
        end
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        begin
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic [31:0] clamp_u32(logic [63:0] x);
        begin
            return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
        end
    endfunction

    function automatic logic [31:0] clamp_s32(logic signed [63:0] x);
        begin
            if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
            if (x < -64'sh8000_0000) return 32'h8000_0000;
            return x[31:0];
        end
    endfunction

    // Computes the result of one request and updates the profile store.
    function automatic motion_t predict_motion(request_t r);
        motion_t m;
        logic signed [63:0] qs, qe, p;
        logic [63:0] v, a, d, tc, tf, t, cend, vel, acc, q;
        logic [127:0] vv, da;
        logic shape_tri;
        int j;
        begin
            m = '0;
            j = int'(r.joint);
            t = {32'd0, r.t};
            if (r.op == OP_LOAD) begin
                qs = {{32{r.qs[31]}}, r.qs};
                qe = {{32{r.qe[31]}}, r.qe};
                v = (r.v == 0) ? 64'd1 : {33'd0, r.v};
                a = (r.a == 0) ? 64'd1 : {33'd0, r.a};
                if (qe < qs) begin
                    m.status = tjp_pkg::STATUS_REJECT;
                    return m;
                end
                d = qe - qs;
                vv = v * v;
                da = d * a;
                shape_tri = (vv >= da);
                if (shape_tri) begin
                    q = ((d / a) << 32) + (((d % a) << 32) / a);
                    tc = int_sqrt(q);
                    tf = 2 * tc;
                end else begin
                    tc = {32'd0, clamp_u32((v << 16) / a)};
                    tf = ((d << 16) / v) + tc;
                end
                prof_qs[j] = qs;
                prof_qe[j] = qe;
                prof_v[j] = v[31:0];
                prof_a[j] = a[31:0];
                prof_tc[j] = clamp_u32(tc);
                prof_tf[j] = clamp_u32(tf);
                prof_tri[j] = shape_tri;
                prof_loaded[j] = 1'b1;
                m.status = tjp_pkg::STATUS_OK;
                return m;
            end
            if (!prof_loaded[j]) begin
                m.status = tjp_pkg::STATUS_UNLOADED;
                return m;
            end
            a = {32'd0, prof_a[j]};
            v = {32'd0, prof_v[j]};
            tc = {32'd0, prof_tc[j]};
            tf = {32'd0, prof_tf[j]};
            cend = prof_tri[j] ? tc : tf - tc;
            if (t <= tc) begin
                m.seg = tjp_pkg::SEG_ACCEL;
                p = prof_qs[j] + $signed(half_accel_dist(a, t));
                vel = mul_q16(a, t);
                m.vel = clamp_s32($signed(vel));
                m.acc = clamp_s32($signed(a));
            end else if (t <= cend) begin
                m.seg = tjp_pkg::SEG_CRUISE;
                p = prof_qs[j] + $signed(half_accel_dist(a, tc))
                    + $signed(mul_q16(v, t - tc));
                m.vel = clamp_s32($signed(v));
            end else if (t <= tf) begin
                m.seg = tjp_pkg::SEG_DECEL;
                p = prof_qe[j] - $signed(half_accel_dist(a, tf - t));
                vel = mul_q16(a, tf - t);
                m.vel = clamp_s32($signed(vel));
                acc = -a;
                m.acc = clamp_s32($signed(acc));
            end else begin
                m.seg = tjp_pkg::SEG_DONE;
                p = prof_qe[j];
            end
            m.pos = clamp_s32(p);
            m.status = tjp_pkg::STATUS_OK;
            return m;
        end
    endfunction

    function automatic request_t make_load(logic j, logic [31:0] qs, logic [31:0] qe,
                                           logic [30:0] v, logic [30:0] a);
        request_t r;
        begin
            r = '0;
            r.op = OP_LOAD;
            r.joint = j;
            r.qs = qs;
            r.qe = qe;
            r.v = v;
            r.a = a;
            r.t = $urandom;
            return r;
        end
    endfunction

    function automatic request_t make_sample(logic j, logic [31:0] t);
        request_t r;
        begin
            r.op = OP_SAMPLE;
            r.joint = j;
            r.t = t;
            r.qs = $urandom;
            r.qe = $urandom;
            r.v = 31'($urandom);
            r.a = 31'($urandom);
            return r;
        end
    endfunction

    // Random limit: mostly moderate magnitudes, sometimes tiny or huge.
    function automatic logic [30:0] rand_limit();
        begin
            case ($urandom_range(0, 5))
                0: return 31'($urandom_range(0, 4));
                1: return 31'($urandom);
                default: return 31'($urandom_range(1, 32'h0040_0000) << $urandom_range(0, 8));
            endcase
        end
    endfunction

    // Driver: presents the next request and holds it until the block takes it.
    always @(posedge clk) begin
        request_t r;
        if (rst_n) begin
            if (start && !busy) begin
                requests_sent <= requests_sent + 1;
            end
            if ((!start || !busy) && pending_requests.size() > 0
                && ($urandom_range(0, 99) >= idle_pct || (start && busy))) begin
                r = pending_requests.pop_front();
                expected_motion.push_back(predict_motion(r));
                start <= 1'b1;
                op <= r.op;
                joint <= r.joint;
                time_req <= r.t;
                start_pos <= r.qs;
                end_pos <= r.qe;
                max_velocity <= r.v;
                max_acceleration <= r.a;
            end else if (!busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compares each strobed result with the oldest expectation.
    always @(posedge clk) begin
        motion_t got, want;
        if (rst_n && done) begin
            got = '{status, position, velocity, acceleration, segment};
            results_seen <= results_seen + 1;
            if (expected_motion.size() == 0) begin
                if (mismatches < 10) $display("unexpected result %p", got);
                mismatches <= mismatches + 1;
            end else begin
                want = expected_motion.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected %p", want);
                        $display("          actual   %p", got);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a request nor a result moves.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                timed_out <= 1'b1;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    always @(posedge clk) begin
        if (timed_out) begin
            $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
            $display("[trapezoidal_joint_profile] ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (pending_requests.size() > 0 || start || busy
                   || expected_motion.size() > 0)
                @(posedge clk);
        end
    endtask

    initial begin
        int k;
        int j;
        logic [31:0] qs;
        logic [31:0] span;
        for (k = 0; k < NJ; k++) begin
            prof_loaded[k] = 1'b0;
            prof_qs[k] = '0;
            prof_qe[k] = '0;
            prof_v[k] = '0;
            prof_a[k] = '0;
            prof_tc[k] = '0;
            prof_tf[k] = '0;
            prof_tri[k] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: unloaded samples, rejects, zero limits, equal ends,
        // extreme positions and limits, and every segment of both profile shapes.
        pending_requests.push_back(make_sample(1'b0, 32'd0));
        pending_requests.push_back(make_sample(1'b1, 32'hFFFF_FFFF));
        pending_requests.push_back(make_load(1'b0, 32'd100, 32'd50, 31'd5, 31'd5));
        pending_requests.push_back(make_sample(1'b0, 32'd10));
        pending_requests.push_back(make_load(1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
                                             31'h7FFF_FFFF, 31'h7FFF_FFFF));
        pending_requests.push_back(make_sample(1'b0, 32'd0));
        pending_requests.push_back(make_sample(1'b0, 32'h0000_8000));
        pending_requests.push_back(make_sample(1'b0, 32'hFFFF_FFFF));
        pending_requests.push_back(make_load(1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                                             31'd0, 31'd0));
        pending_requests.push_back(make_sample(1'b1, 32'h7FFF_FFFF));
        pending_requests.push_back(make_sample(1'b1, 32'hFFFF_FFFF));
        pending_requests.push_back(make_load(1'b1, 32'h0001_0000, 32'h0001_0000,
                                             31'd7, 31'd9));
        pending_requests.push_back(make_sample(1'b1, 32'd0));
        pending_requests.push_back(make_sample(1'b1, 32'd1));
        // Trapezoid: 100 units at 10 units/s, 10 units/s^2: tc 1 s, tf 11 s.
        pending_requests.push_back(make_load(1'b0, 32'hFFF6_0000, 32'h005A_0000,
                                             31'h000A_0000, 31'h000A_0000));
        pending_requests.push_back(make_sample(1'b0, 32'h0000_8000));
        pending_requests.push_back(make_sample(1'b0, 32'h0001_0000));
        pending_requests.push_back(make_sample(1'b0, 32'h0005_0000));
        pending_requests.push_back(make_sample(1'b0, 32'h000A_8000));
        pending_requests.push_back(make_sample(1'b0, 32'h000B_0000));
        pending_requests.push_back(make_sample(1'b0, 32'h000C_0000));
        // Triangle: 4 units with a high velocity limit.
        pending_requests.push_back(make_load(1'b1, 32'd0, 32'h0004_0000,
                                             31'h7FFF_FFFF, 31'h0001_0000));
        pending_requests.push_back(make_sample(1'b1, 32'h0001_0000));
        pending_requests.push_back(make_sample(1'b1, 32'h0003_0000));
        loads_sent = 6;
        samples_sent = 18;
        wait_drained();

        // Random part, four idling phases: well-formed load then samples spread
        // over the profile; a few loads are reversed or random noise.
        for (k = 0; k < 4; k++) begin
            idle_pct = (k == 0) ? 0 : (k == 1) ? 64 : (k == 2) ? 64 : 33;
            while (loads_sent + samples_sent < 24 + (k + 1) * 282) begin
                j = $urandom_range(0, 1);
                if ($urandom_range(0, 9) == 0) begin
                    pending_requests.push_back(make_load(1'(j), $urandom, $urandom,
                                                         31'($urandom), 31'($urandom)));
                end else begin
                    qs = $urandom;
                    span = $urandom_range(0, 3) == 0 ? $urandom
                                                     : $urandom_range(0, 32'h0100_0000);
                    pending_requests.push_back(make_load(1'(j), qs, qs + span,
                                                         rand_limit(), rand_limit()));
                    if ($signed(qs + span) < $signed(qs))
                        pending_requests[$].qe = 32'h7FFF_FFFF;
                end
                loads_sent = loads_sent + 1;
                repeat ($urandom_range(3, 10)) begin
                    pending_requests.push_back(make_sample(1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0 ? $urandom
                                                  : $urandom_range(0, 32'h0040_0000)));
                    samples_sent = samples_sent + 1;
                end
                while (pending_requests.size() > 8) @(posedge clk);
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        $display("covered %0d loads and %0d samples over four idling phases;",
                 loads_sent, samples_sent);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_motion.size() == 0) begin
            $display("[trapezoidal_joint_profile] OK");
        end else begin
            $display("[trapezoidal_joint_profile] ERROR");
        end
        $finish;
    end

endmodule
